// File: src/heightmap_box_smooth_3x3_unit_defines.svh
// Assertion macros for the heightmap smoother RTL, used by hbs3_scan
`ifndef HEIGHTMAP_BOX_SMOOTH_3X3_UNIT_DEFINES_SVH
`define HEIGHTMAP_BOX_SMOOTH_3X3_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define HBS3_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hbs3 check failed");
`define HBS3_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("hbs3 check failed");
`else
`define HBS3_ASSERT(lbl, clk, rst, prop)
`define HBS3_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// File: src/hbs3_pkg.sv
// Shared constants, types and reciprocal table of the heightmap smoother
`default_nettype none

package hbs3_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WID_W      = COL_W + 1;
   localparam int ROW_W      = $clog2(HEIGHT_LIMIT) + 1;
   localparam int PEND_W     = COL_W + 1;
   localparam int CFG_W      = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int PIXEL_W    = 32;
   localparam int HEIGHT_W   = 8;
   localparam int HEIGHT_LSB = 8;
   localparam int LINE_W     = 2 * HEIGHT_W;
   localparam int FRAC_BITS  = 8;
   localparam int OUT_W      = HEIGHT_W + FRAC_BITS;
   localparam int SUM_W      = HEIGHT_W + 4;
   localparam int RECIP_W    = 25;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W     = SUM_W + RECIP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_ENABLE = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // ceil(2^24 / count): exact for (sum << 8) / count over the full sum range
   localparam logic [RECIP_W-1:0] RECIP_BY_1 = 25'd16777216;
   localparam logic [RECIP_W-1:0] RECIP_BY_2 = 25'd8388608;
   localparam logic [RECIP_W-1:0] RECIP_BY_3 = 25'd5592406;
   localparam logic [RECIP_W-1:0] RECIP_BY_4 = 25'd4194304;
   localparam logic [RECIP_W-1:0] RECIP_BY_6 = 25'd2796203;
   localparam logic [RECIP_W-1:0] RECIP_BY_9 = 25'd1864136;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_SHIFT,
      SCAN_REFILL
   } scan_state_type;

   typedef logic [2:0][2:0][HEIGHT_W-1:0] window_type;

   typedef struct packed {
      logic       valid;
      window_type win;
      logic       left_out;
      logic       right_out;
      logic       top_out;
      logic       bottom_out;
      logic       smooth;
      logic       last;
   } window_snap_type;

   function automatic logic [RECIP_W-1:0] hbs3_recip(input logic [1:0] cols,
                                                     input logic [1:0] rows);
      logic [3:0] cnt;
      cnt = {2'b00, cols} * {2'b00, rows};
      unique case (cnt)
         4'd1:    hbs3_recip = RECIP_BY_1;
         4'd2:    hbs3_recip = RECIP_BY_2;
         4'd3:    hbs3_recip = RECIP_BY_3;
         4'd4:    hbs3_recip = RECIP_BY_4;
         4'd6:    hbs3_recip = RECIP_BY_6;
         4'd9:    hbs3_recip = RECIP_BY_9;
         default: hbs3_recip = RECIP_BY_1;
      endcase
   endfunction

endpackage

`default_nettype wire

// File: src/hbs3_line_store.sv
// Two stacked row buffers in one synchronous memory, upper row in the high byte
`default_nettype none

module hbs3_line_store import hbs3_pkg::*; (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [COL_W-1:0]  rd_addr,
   output logic [LINE_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [COL_W-1:0]  wr_addr,
   input  logic [LINE_W-1:0] wr_data
);

   logic [LINE_W-1:0] store_mem [MAX_WIDTH];
   logic [LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/hbs3_scan.sv
// Raster sequencer: request intake, line store read-modify-write, window and counters
`default_nettype none
`include "heightmap_box_smooth_3x3_unit_defines.svh"

module hbs3_scan import hbs3_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [PIXEL_W-1:0]   req_pixel_word,
   input  logic [WID_W-1:0]     image_width,
   input  logic [ROW_W-1:0]     image_height,
   input  logic                 smooth_enable,
   input  logic                 frame_restart,
   output logic                 mem_rd_en,
   output logic [COL_W-1:0]     mem_rd_addr,
   input  logic [LINE_W-1:0]    mem_rd_data,
   output logic                 mem_wr_en,
   output logic [COL_W-1:0]     mem_wr_addr,
   output logic [LINE_W-1:0]    mem_wr_data,
   input  logic                 snap_busy,
   output window_snap_type      snap
);

   scan_state_type      state_ff, state_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [PEND_W-1:0]   pend_ff, pend_in;
   window_type          win_ff, win_in;
   logic [HEIGHT_W-1:0] hgt_ff, hgt_in;
   logic                drain_ff, drain_in;

   logic [HEIGHT_W-1:0] top_rd;
   logic [HEIGHT_W-1:0] mid_rd;
   window_type          win_shift;
   logic [WID_W-1:0]    col_inc;
   logic                col_wrap;
   logic                col_first;
   logic                produce;
   logic [ROW_W-1:0]    center_row;
   logic                left_out;
   logic                right_out;
   logic                top_out;
   logic                bottom_out;
   logic [PEND_W-1:0]   pend_next;
   logic                frame_done;
   logic                accept_work;

   always_comb begin
      top_rd       = mem_rd_data[LINE_W-1:HEIGHT_W];
      mid_rd       = mem_rd_data[HEIGHT_W-1:0];
      win_shift[0] = win_ff[1];
      win_shift[1] = win_ff[2];
      win_shift[2][0] = top_rd;
      win_shift[2][1] = mid_rd;
      win_shift[2][2] = hgt_ff;
      col_inc    = {1'b0, col_ff} + WID_W'(1);
      col_wrap   = col_inc >= image_width;
      col_first  = col_ff == '0;
      produce    = (row_ff >= ROW_W'(2)) || ((row_ff == ROW_W'(1)) && !col_first);
      center_row = col_first ? row_ff - ROW_W'(2) : row_ff - ROW_W'(1);
      left_out   = col_first ? (image_width == WID_W'(1)) : (col_ff == COL_W'(1));
      right_out  = col_first;
      top_out    = center_row == '0;
      bottom_out = ({1'b0, center_row} + (ROW_W+1)'(1)) >= {1'b0, image_height};
      pend_next  = pend_ff + PEND_W'(!drain_ff) - PEND_W'(produce);
      frame_done = drain_ff && produce && (pend_next == '0);
   end

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      pend_in     = pend_ff;
      win_in      = win_ff;
      hgt_in      = hgt_ff;
      drain_in    = drain_ff;
      req_ready   = 1'b0;
      accept_work = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = col_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = col_ff;
      mem_wr_data = {mid_rd, hgt_ff};
      snap            = '0;
      snap.win        = win_shift;
      snap.left_out   = left_out;
      snap.right_out  = right_out;
      snap.top_out    = top_out;
      snap.bottom_out = bottom_out;
      snap.smooth     = smooth_enable;
      snap.last       = frame_done;

      unique case (state_ff)
         SCAN_IDLE: begin
            req_ready = !snap_busy;
            if (req_valid && req_ready) begin
               if (req_operation == OP_PIXEL) begin
                  accept_work = row_ff < image_height;
               end else begin
                  accept_work = (row_ff >= image_height) && (pend_ff != '0);
               end
               if (accept_work) begin
                  hgt_in    = (req_operation == OP_PIXEL) ?
                              req_pixel_word[HEIGHT_LSB +: HEIGHT_W] : '0;
                  drain_in  = req_operation == OP_DRAIN;
                  mem_rd_en = 1'b1;
                  state_in  = SCAN_SHIFT;
               end
            end
         end
         SCAN_REFILL: begin
            mem_rd_en = 1'b1;
            state_in  = SCAN_SHIFT;
         end
         SCAN_SHIFT: begin
            mem_wr_en  = 1'b1;
            win_in     = win_shift;
            pend_in    = pend_next;
            snap.valid = produce;
            if (col_wrap) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_inc[COL_W-1:0];
            end
            if (drain_ff && !produce) begin
               state_in = SCAN_REFILL;
            end else begin
               state_in = SCAN_IDLE;
            end
            if (frame_done) begin
               col_in  = '0;
               row_in  = '0;
               pend_in = '0;
               win_in  = '0;
            end
         end
         default: begin
            state_in = SCAN_IDLE;
         end
      endcase

      if (frame_restart) begin
         col_in  = '0;
         row_in  = '0;
         pend_in = '0;
         win_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         pend_ff  <= '0;
         win_ff   <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pend_ff  <= pend_in;
         win_ff   <= win_in;
         drain_ff <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      hgt_ff <= hgt_in;
   end

   `HBS3_ASSERT(col_below_width, clock, reset, {1'b0, col_ff} < image_width)
   `HBS3_ASSERT(pend_bounded, clock, reset, pend_ff <= PEND_W'(MAX_WIDTH + 1))
   `HBS3_ASSERT(last_clears_frame, clock, reset, snap.valid && snap.last |=> row_ff == '0 && col_ff == '0 && pend_ff == '0)
   `HBS3_ASSERT_NEVER(no_rd_wr_overlap, clock, reset, mem_rd_en && mem_wr_en)

endmodule

`default_nettype wire

// File: src/hbs3_mean.sv
// Masked 3x3 sum, reciprocal multiply and result register
`default_nettype none

module hbs3_mean import hbs3_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  window_snap_type     snap,
   output logic                snap_busy,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [OUT_W-1:0]    rsp_smoothed_height,
   output logic                rsp_frame_last
);

   window_snap_type     a_ff, a_in;
   logic                b_valid_ff, b_valid_in;
   logic [SUM_W-1:0]    b_sum_ff, b_sum_in;
   logic [1:0]          b_cols_ff, b_cols_in;
   logic [1:0]          b_rows_ff, b_rows_in;
   logic [HEIGHT_W-1:0] b_center_ff, b_center_in;
   logic                b_smooth_ff, b_smooth_in;
   logic                b_last_ff, b_last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]    rsp_height_ff, rsp_height_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic                move_b;
   logic                b_free;
   logic                move_a;
   logic [SUM_W-3:0]    col_sum [3];
   logic [SUM_W-1:0]    win_sum;
   logic [PROD_W-1:0]   product;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      move_b   = b_valid_ff && out_free;
      b_free   = !b_valid_ff || move_b;
      move_a   = a_ff.valid && b_free;

      for (int a = 0; a < 3; a++) begin
         col_sum[a] = (a_ff.top_out ? (SUM_W-2)'(0) : (SUM_W-2)'(a_ff.win[a][0]))
                    + (SUM_W-2)'(a_ff.win[a][1])
                    + (a_ff.bottom_out ? (SUM_W-2)'(0) : (SUM_W-2)'(a_ff.win[a][2]));
      end
      win_sum = (a_ff.left_out ? SUM_W'(0) : SUM_W'(col_sum[0]))
              + SUM_W'(col_sum[1])
              + (a_ff.right_out ? SUM_W'(0) : SUM_W'(col_sum[2]));

      a_in = a_ff;
      if (move_a) begin
         a_in.valid = 1'b0;
      end
      if (snap.valid) begin
         a_in = snap;
      end

      b_valid_in  = b_valid_ff;
      b_sum_in    = b_sum_ff;
      b_cols_in   = b_cols_ff;
      b_rows_in   = b_rows_ff;
      b_center_in = b_center_ff;
      b_smooth_in = b_smooth_ff;
      b_last_in   = b_last_ff;
      if (move_b) begin
         b_valid_in = 1'b0;
      end
      if (move_a) begin
         b_valid_in  = 1'b1;
         b_sum_in    = win_sum;
         b_cols_in   = 2'd3 - {1'b0, a_ff.left_out} - {1'b0, a_ff.right_out};
         b_rows_in   = 2'd3 - {1'b0, a_ff.top_out} - {1'b0, a_ff.bottom_out};
         b_center_in = a_ff.win[1][1];
         b_smooth_in = a_ff.smooth;
         b_last_in   = a_ff.last;
      end

      product = PROD_W'(b_sum_ff) * PROD_W'(hbs3_recip(b_cols_ff, b_rows_ff));

      rsp_valid_in  = rsp_valid_ff;
      rsp_height_in = rsp_height_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (move_b) begin
         rsp_valid_in  = 1'b1;
         rsp_height_in = b_smooth_ff ? product[RECIP_SHIFT +: OUT_W]
                                     : OUT_W'(b_center_ff) << FRAC_BITS;
         rsp_last_in   = b_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff         <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_ff         <= a_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_sum_ff      <= b_sum_in;
      b_cols_ff     <= b_cols_in;
      b_rows_ff     <= b_rows_in;
      b_center_ff   <= b_center_in;
      b_smooth_ff   <= b_smooth_in;
      b_last_ff     <= b_last_in;
      rsp_height_ff <= rsp_height_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign snap_busy           = a_ff.valid;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_smoothed_height = rsp_height_ff;
   assign rsp_frame_last      = rsp_last_ff;

endmodule

`default_nettype wire

// File: src/heightmap_box_smooth_3x3_unit.sv
// Heightmap 3x3 box-mean smoother: top level with control registers
// Requests enter on req_ (operation 0 a pixel, 1 a drain tick), results leave on rsp_,
// both valid/ready. Registers are written on csr_ (index, data); csr_ready is always high.
// Each pixel or drain request that does work takes a line store read, then the
// read-modify-write of that store entry and the window shift. A drain tick that
// lands on the start of row 1 (one-row rasters) needs a second read-and-shift
// pass. Ignored requests are taken with no line store read. As the line store read
// is registered, a new request is not taken until the last one's write-back is done.
// The result for pixel p is released by the request that carries pixel p+width+1, or
// by a drain tick after the frame's last pixel (after its second pass, if it needs one).
// rsp_frame_last marks the frame's last result; the raster counters and window clear
// as that result's window leaves the shifter.
// Between the shifter and rsp_ there is a sum stage, a multiply stage and the result
// register; while the receiver stalls these fill, and req_ready falls once the sum
// stage is held. Writing image_width or image_height drops the frame in progress.
// Reset clears the raster counters, the window and the pipeline valid bits and
// loads 256 x 256 with smoothing on; line store contents are not cleared.
`default_nettype none

module heightmap_box_smooth_3x3_unit import hbs3_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [PIXEL_W-1:0]   req_pixel_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OUT_W-1:0]     rsp_smoothed_height,
   output logic                 rsp_frame_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   logic [WID_W-1:0]  width_ff, width_in;
   logic [ROW_W-1:0]  height_ff, height_in;
   logic              smooth_ff, smooth_in;
   logic              frame_restart;
   logic [WID_W-1:0]  width_clamped;
   logic [ROW_W-1:0]  height_clamped;

   logic              mem_rd_en;
   logic [COL_W-1:0]  mem_rd_addr;
   logic [LINE_W-1:0] mem_rd_data;
   logic              mem_wr_en;
   logic [COL_W-1:0]  mem_wr_addr;
   logic [LINE_W-1:0] mem_wr_data;
   logic              snap_busy;
   window_snap_type   snap;

   assign csr_ready = 1'b1;

   always_comb begin
      width_clamped = WID_W'(MAX_WIDTH);
      if (csr_data == '0) begin
         width_clamped = WID_W'(1);
      end else if (int'(csr_data) <= MAX_WIDTH) begin
         width_clamped = WID_W'(csr_data);
      end
      height_clamped = ROW_W'(HEIGHT_LIMIT);
      if (csr_data == '0) begin
         height_clamped = ROW_W'(1);
      end else if (int'(csr_data) <= HEIGHT_LIMIT) begin
         height_clamped = ROW_W'(csr_data);
      end

      width_in      = width_ff;
      height_in     = height_ff;
      smooth_in     = smooth_ff;
      frame_restart = 1'b0;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in      = width_clamped;
               frame_restart = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in     = height_clamped;
               frame_restart = 1'b1;
            end
            CSR_SMOOTH_ENABLE: begin
               smooth_in = csr_data[0];
            end
            default: begin
               frame_restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(256);
         height_ff <= ROW_W'(256);
         smooth_ff <= 1'b1;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         smooth_ff <= smooth_in;
      end
   end

   hbs3_line_store u_line_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   hbs3_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_pixel_word (req_pixel_word),
      .image_width    (width_ff),
      .image_height   (height_ff),
      .smooth_enable  (smooth_ff),
      .frame_restart  (frame_restart),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .snap_busy      (snap_busy),
      .snap           (snap)
   );

   hbs3_mean u_mean (
      .clock               (clock),
      .reset               (reset),
      .snap                (snap),
      .snap_busy           (snap_busy),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_smoothed_height (rsp_smoothed_height),
      .rsp_frame_last      (rsp_frame_last)
   );

endmodule

`default_nettype wire
